// ===== rtl/core/msgseg_pkg.sv =====
`timescale 1ns / 1ps

package msgseg_pkg;

  localparam int unsigned LenW   = 15;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned QDepth = 4;
  localparam int unsigned QAw    = 2;
  localparam int unsigned QCntW  = 3;

  // reciprocal divide: exact floor for any LenW-bit numerator and a divisor up to 2^8
  localparam int unsigned RecipShift = LenW + 8;
  localparam int unsigned RecipW     = RecipShift + 1;
  localparam int unsigned ProdW      = LenW + RecipW;

  localparam logic [ByteW-1:0] IdLast   = 8'd254;
  localparam logic [ByteW-1:0] CountMax = 8'd255;

  typedef struct packed {
    logic             start;
    logic [LenW-1:0]  len;
    logic [ByteW-1:0] total;
    logic [ByteW-1:0] id;
    logic [ByteW-1:0] data;
  } q_word_t;

endpackage

// ===== rtl/core/msgseg_front.sv =====
`timescale 1ns / 1ps

module msgseg_front #(
  parameter int unsigned PAYLOAD_MAX = 128
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [msgseg_pkg::LenW-1:0]  len_i,
  input  logic [msgseg_pkg::ByteW-1:0] data_i,
  output logic                       push_o,
  output msgseg_pkg::q_word_t        word_o,
  input  logic                       full_i
);
  import msgseg_pkg::*;

  localparam logic [RecipW-1:0] RecipMul =
    RecipW'(((64'd1 << RecipShift) + 64'(PAYLOAD_MAX) - 64'd1) / 64'(PAYLOAD_MAX));

  logic             in_msg_q, in_msg_d;
  logic [LenW-1:0]  left_q, left_d;
  logic [ByteW-1:0] next_id_q, next_id_d;
  logic [ByteW-1:0] cur_id_q, cur_id_d;
  logic [ProdW-1:0] prod;
  logic [ProdW-RecipShift-1:0] quot;
  logic [ByteW-1:0] total;
  logic             accept;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;

  assign prod  = ProdW'(len_i) * ProdW'(RecipMul);
  assign quot  = prod[ProdW-1:RecipShift];
  assign total = (quot >= (ProdW-RecipShift)'(CountMax)) ? CountMax : ByteW'(quot + 1'b1);

  always_comb begin
    in_msg_d  = in_msg_q;
    left_d    = left_q;
    next_id_d = next_id_q;
    cur_id_d  = cur_id_q;
    push_o    = 1'b0;
    word_o.start = !in_msg_q;
    word_o.len   = len_i;
    word_o.total = total;
    word_o.id    = in_msg_q ? cur_id_q : next_id_q;
    word_o.data  = data_i;
    if (accept) begin
      if (!in_msg_q) begin
        cur_id_d  = next_id_q;
        next_id_d = (next_id_q >= IdLast) ? '0 : next_id_q + 1'b1;
        if (len_i != '0) begin
          push_o   = 1'b1;
          left_d   = len_i - 1'b1;
          in_msg_d = (len_i > LenW'(1));
        end
      end else begin
        push_o   = 1'b1;
        left_d   = left_q - 1'b1;
        in_msg_d = (left_q > LenW'(1));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_msg_q  <= 1'b0;
      left_q    <= '0;
      next_id_q <= '0;
      cur_id_q  <= '0;
    end else begin
      in_msg_q  <= in_msg_d;
      left_q    <= left_d;
      next_id_q <= next_id_d;
      cur_id_q  <= cur_id_d;
    end
  end

endmodule

// ===== rtl/core/msgseg_queue.sv =====
`timescale 1ns / 1ps

module msgseg_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  msgseg_pkg::q_word_t word_i,
  output logic                full_o,
  output logic                valid_o,
  input  logic                pop_i,
  output msgseg_pkg::q_word_t word_o
);
  import msgseg_pkg::*;

  q_word_t          mem_q [QDepth];
  logic [QAw-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign valid_o = (cnt_q != '0);
  assign word_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ===== rtl/core/msgseg_back.sv =====
`timescale 1ns / 1ps

module msgseg_back #(
  parameter int unsigned PAYLOAD_MAX = 128
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       q_valid_i,
  input  msgseg_pkg::q_word_t        q_word_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [msgseg_pkg::ByteW-1:0] id_o,
  output logic [msgseg_pkg::ByteW-1:0] index_o,
  output logic [msgseg_pkg::ByteW-1:0] total_o,
  output logic [msgseg_pkg::ByteW-1:0] plen_o,
  output logic [msgseg_pkg::ByteW-1:0] byte_o,
  output logic                       first_o,
  output logic                       last_o,
  output logic                       eom_o
);
  import msgseg_pkg::*;

  localparam logic [ByteW-1:0] PayMax = ByteW'(PAYLOAD_MAX);

  logic [LenW-1:0]  left_q;
  logic [ByteW-1:0] pkt_q, bip_q, plen_q, id_q, total_q;
  logic [LenW-1:0]  cur_left, left_nxt;
  logic [ByteW-1:0] cur_pkt, cur_bip, cur_plen, cur_id, cur_total, start_plen, nxt_plen;
  logic             first, last, eom;
  logic             out_valid_q;

  function automatic logic [ByteW-1:0] plen_for(input logic [LenW-1:0] rem);
    plen_for = (rem < LenW'(PayMax)) ? rem[ByteW-1:0] : PayMax;
  endfunction

  assign pop_o       = q_valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;

  assign start_plen = plen_for(q_word_i.len);
  assign cur_left   = q_word_i.start ? q_word_i.len   : left_q;
  assign cur_pkt    = q_word_i.start ? '0             : pkt_q;
  assign cur_bip    = q_word_i.start ? '0             : bip_q;
  assign cur_plen   = q_word_i.start ? start_plen     : plen_q;
  assign cur_id     = q_word_i.start ? q_word_i.id    : id_q;
  assign cur_total  = q_word_i.start ? q_word_i.total : total_q;

  assign first    = (cur_bip == '0);
  assign last     = ({1'b0, cur_bip} + 9'd1 >= {1'b0, cur_plen});
  assign eom      = (cur_left <= LenW'(1));
  assign left_nxt = (cur_left != '0) ? cur_left - 1'b1 : '0;
  assign nxt_plen = plen_for(left_nxt);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      left_q      <= '0;
      pkt_q       <= '0;
      bip_q       <= '0;
      plen_q      <= '0;
      id_q        <= '0;
      total_q     <= '0;
    end else begin
      if (pop_o) begin
        out_valid_q <= 1'b1;
        left_q      <= left_nxt;
        id_q        <= cur_id;
        total_q     <= cur_total;
        if (last) begin
          bip_q  <= '0;
          pkt_q  <= (cur_pkt < CountMax) ? cur_pkt + 1'b1 : cur_pkt;
          plen_q <= nxt_plen;
        end else begin
          bip_q  <= cur_bip + 1'b1;
          pkt_q  <= cur_pkt;
          plen_q <= cur_plen;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // output word, no reset
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      id_o    <= cur_id;
      index_o <= cur_pkt;
      total_o <= cur_total;
      plen_o  <= cur_plen;
      byte_o  <= q_word_i.data;
      first_o <= first;
      last_o  <= last;
      eom_o   <= eom;
    end
  end

endmodule

// ===== rtl/core/message_segmenter_unit.sv =====
`timescale 1ns / 1ps

// message segmenter
// input stream: one message byte per word; the first word of a message also
// carries the message length (bits 14:0), the byte sits in bits 22:15. a first
// word with length zero uses up a message id and gives no output word.
// output stream: one word per byte, tagged with message id, packet index,
// packet total (length / PAYLOAD_MAX + 1, saturated at 255) and packet length;
// tlast marks the last byte of a packet, tuser carries first-of-packet and
// end-of-message.
// an accepted input word passes the combinational classify stage into the
// 4-word queue and then goes through the output register. throughput: one
// word per cycle in steady flow.
// the front keeps taking words while the queue has room, so a stalled receiver
// stops the input only after 4 words plus the output register are held.
// reset clears the message id to 0 and leaves the block idle between messages.
// data and tags are held stable while tvalid is high and tready low.
module message_segmenter_unit #(
  parameter int unsigned PAYLOAD_MAX = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // message_length[14:0], data_byte[22:15], zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // msg id, pkt index, pkt total,
                                     // pkt len, byte (8 bits each)
  output logic        m_axis_tlast,  // last_of_packet
  output logic [1:0]  m_axis_tuser   // first_of_packet, end_of_message
);
  import msgseg_pkg::*;

  q_word_t push_word, pop_word;
  logic    push, full, q_valid, pop;

  msgseg_front #(.PAYLOAD_MAX(PAYLOAD_MAX)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .len_i      (s_axis_tdata[14:0]),
    .data_i     (s_axis_tdata[22:15]),
    .push_o     (push),
    .word_o     (push_word),
    .full_i     (full)
  );

  msgseg_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .word_i  (push_word),
    .full_o  (full),
    .valid_o (q_valid),
    .pop_i   (pop),
    .word_o  (pop_word)
  );

  msgseg_back #(.PAYLOAD_MAX(PAYLOAD_MAX)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_word_i    (pop_word),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .id_o        (m_axis_tdata[7:0]),
    .index_o     (m_axis_tdata[15:8]),
    .total_o     (m_axis_tdata[23:16]),
    .plen_o      (m_axis_tdata[31:24]),
    .byte_o      (m_axis_tdata[39:32]),
    .first_o     (m_axis_tuser[0]),
    .last_o      (m_axis_tlast),
    .eom_o       (m_axis_tuser[1])
  );

endmodule

// ===== rtl/core/msgseg_checker.sv =====
`timescale 1ns / 1ps

module msgseg_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic        m_axis_tlast,
  input logic [1:0]  m_axis_tuser
);

  logic expect_first_q, expect_first_d;
  logic out_acc;

  assign out_acc        = m_axis_tvalid && m_axis_tready;
  assign expect_first_d = out_acc ? m_axis_tlast : expect_first_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expect_first_q <= 1'b1;
    end else begin
      expect_first_q <= expect_first_d;
    end
  end

  // stalled word holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser))
    else $error("output word changed while stalled");

  a_eom_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast)
    else $error("end of message without end of packet");

  a_first_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> (m_axis_tuser[0] == expect_first_q))
    else $error("first-of-packet mark out of step with tlast");

  a_plen_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[31:24] != 8'd0) && (m_axis_tdata[23:16] != 8'd0))
    else $error("zero packet length or total");

endmodule

bind message_segmenter_unit msgseg_checker u_msgseg_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);
